FILE: design/time_ordered_event_queue_unit_defines.svh
// Assertion helpers for the time ordered event queue.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef TIME_ORDERED_EVENT_QUEUE_UNIT_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked outside reset
`define TOEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("toeq assertion failed");
// same-cycle implication, checked outside reset
`define TOEQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("toeq implication failed");
`else
`define TOEQ_ASSERT(label, clk, rst, prop)
`define TOEQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/toeq_pkg.sv
package toeq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int KEY_W  = 32;
   localparam int JOB_W  = 16;
   localparam int KIND_W = 3;
   localparam int OCC_W  = 7;

   localparam int ENTRY_W    = KEY_W + JOB_W + KIND_W;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 3;

   // operation codes carried in req_tuser
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // key sits in the low bits, matching the tdata layout
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [JOB_W-1:0]  job;
      logic [KEY_W-1:0]  key;
   } entry_type;

   typedef struct packed {
      logic [OCC_W-1:0] occ;
      status_type       status;
      logic             popped;
      entry_type        entry;
   } result_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch request, set up scan pointers
      logic rd_head;    // read oldest entry
      logic rd_scan;    // read entry below the hole
      logic shift;      // move read entry up into the hole
      logic place;      // write new entry into the hole
      logic pop_commit; // retire head, build pop result
      logic err;        // build full/empty result
      logic load_out;   // result -> output register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_push;
      logic full;
      logic empty;
      logic scan_done;
      logic key_gt;
   } ctl_sts_type;

endpackage

FILE: design/toeq_datapath.sv
`include "time_ordered_event_queue_unit_defines.svh"

module toeq_datapath #(
   parameter int DEPTH = toeq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [toeq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [toeq_pkg::REQ_USER_W-1:0]     req_tuser,
   input  toeq_pkg::ctl_cmd_type               cmd,
   output toeq_pkg::ctl_sts_type               sts,
   output logic [toeq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [toeq_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   toeq_pkg::entry_type  mem [DEPTH];

   logic [AW-1:0]        head_ff, wptr_ff, rptr_ff;
   logic [CW-1:0]        count_ff, remain_ff;
   logic                 op_ff;
   toeq_pkg::entry_type  new_ff, rd_data_ff;
   toeq_pkg::result_type res_ff, out_ff;

   logic [AW:0]          tail_sum;
   logic [AW-1:0]        tail_ptr, rd_addr;
   toeq_pkg::entry_type  wr_data, req_entry;

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      if (p == '0) begin
         r = AW'(DEPTH - 1);
      end else begin
         r = p - 1'b1;
      end
      return r;
   endfunction

   // physical slot just past the youngest entry
   assign tail_sum = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
   assign tail_ptr = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                    : AW'(tail_sum);

   assign req_entry = toeq_pkg::ENTRY_W'(req_tdata[toeq_pkg::ENTRY_W-1:0]);
   assign rd_addr   = cmd.rd_head ? head_ff : rptr_ff;
   assign wr_data   = cmd.shift ? rd_data_ff : new_ff;

   assign sts.is_push   = (op_ff == toeq_pkg::CMD_PUSH);
   assign sts.full      = (count_ff == CW'(DEPTH));
   assign sts.empty     = (count_ff == '0);
   assign sts.scan_done = (remain_ff == '0);
   assign sts.key_gt    = (rd_data_ff.key > new_ff.key);

   // entry store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.shift || cmd.place) begin
         mem[wptr_ff] <= wr_data;
      end
      if (cmd.rd_head || cmd.rd_scan) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // queue control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.place) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pop_commit) begin
            count_ff <= count_ff - 1'b1;
            head_ff  <= (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
      end
   end

   // request staging and backward insertion scan
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_tuser[0];
         new_ff    <= req_entry;
         wptr_ff   <= tail_ptr;
         rptr_ff   <= ptr_dec(tail_ptr);
         remain_ff <= count_ff;
      end else if (cmd.shift) begin
         wptr_ff   <= rptr_ff;
         rptr_ff   <= ptr_dec(rptr_ff);
         remain_ff <= remain_ff - 1'b1;
      end
   end

   // result build, then output register
   always_ff @(posedge clock) begin
      if (cmd.place) begin
         res_ff.entry  <= '0;
         res_ff.popped <= 1'b0;
         res_ff.status <= toeq_pkg::ST_OK;
         res_ff.occ    <= toeq_pkg::OCC_W'(count_ff + 1'b1);
      end else if (cmd.pop_commit) begin
         res_ff.entry  <= rd_data_ff;
         res_ff.popped <= 1'b1;
         res_ff.status <= toeq_pkg::ST_OK;
         res_ff.occ    <= toeq_pkg::OCC_W'(count_ff - 1'b1);
      end else if (cmd.err) begin
         res_ff.entry  <= '0;
         res_ff.popped <= 1'b0;
         res_ff.status <= sts.is_push ? toeq_pkg::ST_FULL : toeq_pkg::ST_EMPTY;
         res_ff.occ    <= toeq_pkg::OCC_W'(count_ff);
      end
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_tdata = toeq_pkg::RSP_DATA_W'({out_ff.occ, out_ff.entry});
   assign rsp_tuser = {out_ff.status, out_ff.popped};

   `TOEQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `TOEQ_ASSERT_IMPL(a_pop_nonempty, clock, reset, cmd.pop_commit, count_ff != '0)
   `TOEQ_ASSERT_IMPL(a_shift_in_range, clock, reset, cmd.shift, remain_ff != '0 && sts.key_gt)

endmodule

FILE: design/toeq_ctrl.sv
`include "time_ordered_event_queue_unit_defines.svh"

module toeq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  toeq_pkg::ctl_sts_type sts,
   output toeq_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      SCAN_CMP,
      SCAN_NEXT,
      POP_WAIT,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff;
   logic      out_free;

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = CHECK;
            end
         end
         CHECK: begin
            priority if (sts.is_push && sts.full) begin
               cmd.err  = 1'b1;
               state_in = EMIT;
            end else if (sts.is_push && sts.scan_done) begin
               cmd.place = 1'b1;
               state_in  = EMIT;
            end else if (sts.is_push) begin
               cmd.rd_scan = 1'b1;
               state_in    = SCAN_CMP;
            end else if (sts.empty) begin
               cmd.err  = 1'b1;
               state_in = EMIT;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = POP_WAIT;
            end
         end
         SCAN_CMP: begin
            if (sts.key_gt) begin
               cmd.shift = 1'b1;
               state_in  = SCAN_NEXT;
            end else begin
               cmd.place = 1'b1;
               state_in  = EMIT;
            end
         end
         SCAN_NEXT: begin
            if (sts.scan_done) begin
               cmd.place = 1'b1;
               state_in  = EMIT;
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = SCAN_CMP;
            end
         end
         POP_WAIT: begin
            cmd.pop_commit = 1'b1;
            state_in       = EMIT;
         end
         EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   `TOEQ_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.load_out, !rsp_tvalid_ff || rsp_tready)
   `TOEQ_ASSERT(a_accept_to_check, clock, reset,
                req_tvalid && req_tready |=> state_ff == CHECK)
   `TOEQ_ASSERT(a_pop_read_order, clock, reset,
                state_ff == POP_WAIT |-> $past(state_ff) == CHECK && $past(cmd.rd_head))

endmodule

FILE: design/time_ordered_event_queue_unit.sv
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tuser: cmd; tdata: event_key, job_id, event_kind
// rsp     | out | rsp_tvalid/rsp_tready | tuser: popped, status; tdata: entry, occupancy
//
// Steps, accept to result: a pop reads the head entry, then retires it and
// builds its result; a rejected push or pop builds a full or empty status
// result directly; a push scans backward from the tail, reading each stored
// entry with a key greater than the new one and moving it up one slot into
// the hole, then writes the new entry into the hole.
// Reset: synchronous, active high; empties the queue. The store itself is
// not cleared and needs no clearing pass.
// Stalls: a finished result waits in the output register while the next
// request is taken; work stalls only if a second result is ready first.
module time_ordered_event_queue_unit #(
   parameter int DEPTH = toeq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] event_key, [47:32] job_id, [50:48] event_kind, [55:51] zero
   input  logic [toeq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] cmd
   input  logic [toeq_pkg::REQ_USER_W-1:0]     req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] out_key, [47:32] out_job, [50:48] out_kind, [57:51] occupancy, [63:58] zero
   output logic [toeq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] popped, [2:1] status
   output logic [toeq_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   toeq_pkg::ctl_cmd_type cmd;
   toeq_pkg::ctl_sts_type sts;

   // The store is a sorted circular buffer: the head slot holds the earliest
   // event, so a pop is one read plus a head bump. A push opens a hole at the
   // tail and walks it down past every entry with a strictly larger key, which
   // keeps equal keys in arrival order.
   toeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   toeq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
